@@ hw/rtl/der_pkg.sv @@
// shared types and constants for the discrete emission re-estimator
// no dependencies

package der_pkg;

   localparam int PROB_W     = 17;
   localparam int ACC_W      = 33;
   localparam int SYM_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int DIV_STEPS  = 17;
   localparam int DIV_CNT_W  = 5;

   localparam logic [PROB_W-1:0] ONE_Q16 = 17'h10000;
   localparam logic [ACC_W-1:0]  ACC_MAX = 33'h1_FFFF_FFFF;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE_UPDATE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARN_RATE    = 2'd1;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_OBSERVE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACC,
      ST_DIS_RD,
      ST_DIS_EMIT,
      ST_P1_RD,
      ST_P1_LOAD,
      ST_DIV,
      ST_MUL0,
      ST_MUL1,
      ST_P1_WB,
      ST_P2_RD,
      ST_P2_LOAD,
      ST_P2_EMIT
   } state_type;

endpackage

@@ hw/rtl/der_ram.sv @@
// generic single write port, single read port ram with registered read data
// no dependencies

module der_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/discrete_emission_reestimate.sv @@
// Discrete emission re-estimator. Table loads write the probability ram directly and
// observations do a read-modify-write of the count ram. The observation marked last
// starts the update pass, during which req_stall stays high. With the update enabled the
// first sweep divides each count by the weight total (old value kept if it is zero) and
// writes back its blend with the old value; the second divides each blend by the blended
// sum (zero if that sum is zero). Both use the shared 17-step restoring divider, and one
// 17x17 multiplier is used twice per entry for the blend. With the update disabled the
// table is read back unchanged. Output backpressure stalls the emitting states. Registers
// may only be written while no transaction is in progress.
// depends on der_pkg and der_ram

module discrete_emission_reestimate #(
   parameter int ALPHABET_SIZE = 16
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_cmd,
   input  logic [der_pkg::SYM_W-1:0]       req_symbol,
   input  logic [der_pkg::PROB_W-1:0]      req_value,
   input  logic                            req_last,

   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [der_pkg::SYM_W-1:0]       rsp_out_symbol,
   output logic [der_pkg::PROB_W-1:0]      rsp_probability,
   output logic                            rsp_final_entry,

   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [der_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [der_pkg::PROB_W-1:0]      csr_data
);

   localparam int AW = $clog2(ALPHABET_SIZE);
   localparam int SW = der_pkg::PROB_W + AW;
   localparam int PW = der_pkg::PROB_W;
   localparam int CW = der_pkg::ACC_W;
   localparam logic [AW-1:0] K_LAST = AW'(ALPHABET_SIZE - 1);

   der_pkg::state_type state_ff, state_in;

   logic [AW-1:0]       k_ff, k_in;
   logic [AW-1:0]       sym_ff, sym_in;
   logic                in_range_ff, in_range_in;
   logic [PW-1:0]       val_ff, val_in;
   logic                last_ff, last_in;
   logic [PW-1:0]       old_ff, old_in;
   logic [PW-1:0]       quo_ff, quo_in;
   logic [CW-1:0]       rem_ff, rem_in;
   logic [CW-1:0]       dvs_ff, dvs_in;
   logic [PW-1:0]       feed_ff, feed_in;
   logic [der_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                pass2_ff, pass2_in;
   logic [CW-1:0]       acc_ff, acc_in;
   logic [CW-1:0]       prod_ff, prod_in;
   logic [SW-1:0]       blended_sum_ff, blended_sum_in;
   logic [CW-1:0]       total_ff, total_in;
   logic [ALPHABET_SIZE-1:0] cvalid_ff, cvalid_in;
   logic                enable_ff, enable_in;
   logic [PW-1:0]       learn_rate_ff, learn_rate_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [der_pkg::SYM_W-1:0] rsp_sym_ff, rsp_sym_in;
   logic [PW-1:0]       rsp_prob_ff, rsp_prob_in;
   logic                rsp_final_ff, rsp_final_in;

   // ram ports
   logic                prob_we, prob_re;
   logic [AW-1:0]       prob_waddr, prob_raddr;
   logic [PW-1:0]       prob_wdata, prob_rdata;
   logic                cnt_we, cnt_re;
   logic [AW-1:0]       cnt_waddr, cnt_raddr;
   logic [CW-1:0]       cnt_wdata, cnt_rdata;

   // combinational helpers
   logic                req_accept;
   logic                req_in_range;
   logic [AW-1:0]       req_idx;
   logic [PW-1:0]       req_val_sat;
   logic                out_free;
   logic                out_load;
   logic [PW-1:0]       out_prob;
   logic [PW-1:0]       eta;
   logic [PW-1:0]       one_minus_eta;
   logic [PW-1:0]       mul_a, mul_b;
   logic [2*PW-1:0]     product;
   logic [CW:0]         blend_full;
   logic [PW-1:0]       blend;
   logic [CW-1:0]       cnt_cur;
   logic [CW:0]         cnt_sum, tot_sum;
   logic [CW-1:0]       cnt_sat, tot_sat;
   logic [CW:0]         div_trial;
   logic [CW:0]         div_diff;
   logic                div_ge;
   logic                k_is_last;

   der_ram #(.WIDTH(PW), .DEPTH(ALPHABET_SIZE)) u_prob_ram (
      .clock   (clock),
      .wr_en   (prob_we),
      .wr_addr (prob_waddr),
      .wr_data (prob_wdata),
      .rd_en   (prob_re),
      .rd_addr (prob_raddr),
      .rd_data (prob_rdata)
   );

   der_ram #(.WIDTH(CW), .DEPTH(ALPHABET_SIZE)) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_en   (cnt_re),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   assign req_stall    = (state_ff != der_pkg::ST_IDLE);
   assign req_accept   = req_valid && !req_stall;
   assign req_in_range = int'(req_symbol) < ALPHABET_SIZE;
   assign req_idx      = AW'(req_symbol);
   assign req_val_sat  = (req_value > der_pkg::ONE_Q16) ? der_pkg::ONE_Q16 : req_value;

   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_symbol  = rsp_sym_ff;
   assign rsp_probability = rsp_prob_ff;
   assign rsp_final_entry = rsp_final_ff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign k_is_last = (k_ff == K_LAST);

   assign eta = (learn_rate_ff > der_pkg::ONE_Q16) ? der_pkg::ONE_Q16 : learn_rate_ff;
   assign one_minus_eta = der_pkg::ONE_Q16 - eta;

   // shared multiplier
   assign mul_a   = (state_ff == der_pkg::ST_MUL0) ? old_ff : quo_ff;
   assign mul_b   = (state_ff == der_pkg::ST_MUL0) ? one_minus_eta : eta;
   assign product = {{PW{1'b0}}, mul_a} * {{PW{1'b0}}, mul_b};

   assign blend_full = {1'b0, acc_ff} + {1'b0, prod_ff};
   assign blend      = blend_full[CW-1:16];

   // count accumulation
   assign cnt_cur = cvalid_ff[sym_ff] ? cnt_rdata : '0;
   assign cnt_sum = {1'b0, cnt_cur} + (CW+1)'(val_ff);
   assign tot_sum = {1'b0, total_ff} + (CW+1)'(val_ff);
   assign cnt_sat = (cnt_sum > {1'b0, der_pkg::ACC_MAX}) ? der_pkg::ACC_MAX : cnt_sum[CW-1:0];
   assign tot_sat = (tot_sum > {1'b0, der_pkg::ACC_MAX}) ? der_pkg::ACC_MAX : tot_sum[CW-1:0];

   // one restoring division step
   assign div_trial = {rem_ff, feed_ff[PW-1]};
   assign div_ge    = (div_trial >= {1'b0, dvs_ff});
   assign div_diff  = div_trial - {1'b0, dvs_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         der_pkg::ST_IDLE: begin
            if (req_accept && req_cmd == der_pkg::CMD_OBSERVE) begin
               state_in = der_pkg::ST_ACC;
            end
         end
         der_pkg::ST_ACC: begin
            if (!last_ff) begin
               state_in = der_pkg::ST_IDLE;
            end else if (enable_ff) begin
               state_in = der_pkg::ST_P1_RD;
            end else begin
               state_in = der_pkg::ST_DIS_RD;
            end
         end
         der_pkg::ST_DIS_RD:   state_in = der_pkg::ST_DIS_EMIT;
         der_pkg::ST_DIS_EMIT: begin
            if (out_free) begin
               state_in = k_is_last ? der_pkg::ST_IDLE : der_pkg::ST_DIS_RD;
            end
         end
         der_pkg::ST_P1_RD:    state_in = der_pkg::ST_P1_LOAD;
         der_pkg::ST_P1_LOAD: begin
            state_in = (total_ff == '0) ? der_pkg::ST_MUL0 : der_pkg::ST_DIV;
         end
         der_pkg::ST_DIV: begin
            if (div_cnt_ff == '0) begin
               state_in = pass2_ff ? der_pkg::ST_P2_EMIT : der_pkg::ST_MUL0;
            end
         end
         der_pkg::ST_MUL0:     state_in = der_pkg::ST_MUL1;
         der_pkg::ST_MUL1:     state_in = der_pkg::ST_P1_WB;
         der_pkg::ST_P1_WB: begin
            state_in = k_is_last ? der_pkg::ST_P2_RD : der_pkg::ST_P1_RD;
         end
         der_pkg::ST_P2_RD:    state_in = der_pkg::ST_P2_LOAD;
         der_pkg::ST_P2_LOAD: begin
            state_in = (blended_sum_ff == '0) ? der_pkg::ST_P2_EMIT : der_pkg::ST_DIV;
         end
         der_pkg::ST_P2_EMIT: begin
            if (out_free) begin
               state_in = k_is_last ? der_pkg::ST_IDLE : der_pkg::ST_P2_RD;
            end
         end
         default: state_in = der_pkg::ST_IDLE;
      endcase
   end

   // ram controls and output load
   always_comb begin
      prob_we    = 1'b0;
      prob_waddr = k_ff;
      prob_wdata = quo_ff;
      prob_re    = 1'b0;
      prob_raddr = k_ff;
      cnt_we     = 1'b0;
      cnt_waddr  = sym_ff;
      cnt_wdata  = cnt_sat;
      cnt_re     = 1'b0;
      cnt_raddr  = k_ff;
      out_load   = 1'b0;
      out_prob   = quo_ff;
      unique case (state_ff)
         der_pkg::ST_IDLE: begin
            if (req_accept && req_in_range) begin
               if (req_cmd == der_pkg::CMD_LOAD) begin
                  prob_we    = 1'b1;
                  prob_waddr = req_idx;
                  prob_wdata = req_val_sat;
               end else begin
                  cnt_re    = 1'b1;
                  cnt_raddr = req_idx;
               end
            end
         end
         der_pkg::ST_ACC: begin
            cnt_we = in_range_ff;
         end
         der_pkg::ST_DIS_RD, der_pkg::ST_P2_RD: begin
            prob_re = 1'b1;
         end
         der_pkg::ST_P1_RD: begin
            prob_re = 1'b1;
            cnt_re  = 1'b1;
         end
         der_pkg::ST_DIS_EMIT: begin
            out_load = out_free;
            out_prob = prob_rdata;
         end
         der_pkg::ST_P1_WB: begin
            prob_we    = 1'b1;
            prob_wdata = blend;
         end
         der_pkg::ST_P2_EMIT: begin
            out_load = out_free;
            prob_we  = out_free;
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      k_in           = k_ff;
      sym_in         = sym_ff;
      in_range_in    = in_range_ff;
      val_in         = val_ff;
      last_in        = last_ff;
      old_in         = old_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      dvs_in         = dvs_ff;
      feed_in        = feed_ff;
      div_cnt_in     = div_cnt_ff;
      pass2_in       = pass2_ff;
      acc_in         = acc_ff;
      prod_in        = prod_ff;
      blended_sum_in = blended_sum_ff;
      total_in       = total_ff;
      cvalid_in      = cvalid_ff;
      enable_in      = enable_ff;
      learn_rate_in  = learn_rate_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            der_pkg::CSR_ENABLE_UPDATE: enable_in     = csr_data[0];
            der_pkg::CSR_LEARN_RATE:    learn_rate_in = csr_data;
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         der_pkg::ST_IDLE: begin
            if (req_accept) begin
               sym_in      = req_idx;
               in_range_in = req_in_range;
               val_in      = req_val_sat;
               last_in     = req_last;
            end
         end
         der_pkg::ST_ACC: begin
            if (in_range_ff) begin
               cvalid_in[sym_ff] = 1'b1;
               total_in          = tot_sat;
            end
            k_in     = '0;
            pass2_in = 1'b0;
            if (last_ff && enable_ff) begin
               blended_sum_in = '0;
            end
         end
         der_pkg::ST_DIS_EMIT, der_pkg::ST_P2_EMIT: begin
            if (out_free) begin
               k_in = k_ff + AW'(1);
               if (k_is_last) begin
                  cvalid_in = '0;
                  total_in  = '0;
               end
            end
         end
         der_pkg::ST_P1_LOAD: begin
            old_in = prob_rdata;
            if (total_ff == '0) begin
               quo_in = prob_rdata;
            end else begin
               rem_in     = {1'b0, (cvalid_ff[k_ff] ? cnt_rdata[CW-1:1] : (CW-1)'(0))};
               feed_in    = {(cvalid_ff[k_ff] & cnt_rdata[0]), (PW-1)'(0)};
               dvs_in     = total_ff;
               quo_in     = '0;
               div_cnt_in = der_pkg::DIV_CNT_W'(der_pkg::DIV_STEPS - 1);
            end
         end
         der_pkg::ST_P2_LOAD: begin
            if (blended_sum_ff == '0) begin
               quo_in = '0;
            end else begin
               rem_in     = CW'(prob_rdata[PW-1:1]);
               feed_in    = {prob_rdata[0], (PW-1)'(0)};
               dvs_in     = CW'(blended_sum_ff);
               quo_in     = '0;
               div_cnt_in = der_pkg::DIV_CNT_W'(der_pkg::DIV_STEPS - 1);
            end
         end
         der_pkg::ST_DIV: begin
            rem_in     = div_ge ? div_diff[CW-1:0] : div_trial[CW-1:0];
            quo_in     = {quo_ff[PW-2:0], div_ge};
            feed_in    = {feed_ff[PW-2:0], 1'b0};
            div_cnt_in = div_cnt_ff - der_pkg::DIV_CNT_W'(1);
         end
         der_pkg::ST_MUL0: begin
            acc_in = product[CW-1:0];
         end
         der_pkg::ST_MUL1: begin
            prod_in = product[CW-1:0];
         end
         der_pkg::ST_P1_WB: begin
            blended_sum_in = blended_sum_ff + SW'(blend);
            k_in           = k_is_last ? '0 : k_ff + AW'(1);
            if (k_is_last) begin
               pass2_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_sym_in   = rsp_sym_ff;
      rsp_prob_in  = rsp_prob_ff;
      rsp_final_in = rsp_final_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_sym_in   = der_pkg::SYM_W'(k_ff);
         rsp_prob_in  = out_prob;
         rsp_final_in = k_is_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= der_pkg::ST_IDLE;
         k_ff           <= '0;
         pass2_ff       <= 1'b0;
         div_cnt_ff     <= '0;
         blended_sum_ff <= '0;
         total_ff       <= '0;
         cvalid_ff      <= '0;
         enable_ff      <= 1'b1;
         learn_rate_ff  <= der_pkg::ONE_Q16;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         k_ff           <= k_in;
         pass2_ff       <= pass2_in;
         div_cnt_ff     <= div_cnt_in;
         blended_sum_ff <= blended_sum_in;
         total_ff       <= total_in;
         cvalid_ff      <= cvalid_in;
         enable_ff      <= enable_in;
         learn_rate_ff  <= learn_rate_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff       <= sym_in;
      in_range_ff  <= in_range_in;
      val_ff       <= val_in;
      last_ff      <= last_in;
      old_ff       <= old_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      dvs_ff       <= dvs_in;
      feed_ff      <= feed_in;
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
      rsp_sym_ff   <= rsp_sym_in;
      rsp_prob_ff  <= rsp_prob_in;
      rsp_final_ff <= rsp_final_in;
   end

   // partial remainder stays below the divisor
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == der_pkg::ST_DIV) |-> (rem_ff < dvs_ff))
      else $error("divider remainder not below divisor");

   // emitted probability never exceeds one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_prob_ff <= der_pkg::ONE_Q16))
      else $error("emitted probability above one");

   // accumulators are cleared once the final entry is loaded
   assert property (@(posedge clock) disable iff (reset)
      (out_load && k_is_last) |=> (total_ff == '0 && cvalid_ff == '0))
      else $error("histogram not cleared after emit");

   // no new transaction is taken while the update pass runs
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == der_pkg::ST_ACC && last_ff) |=> req_stall)
      else $error("input accepted during update pass");

endmodule

@@ bench/tb.sv @@
// testbench for discrete_emission_reestimate: directed table, then random load/observe traffic
// checked entry by entry against an in-bench fixed-point re-estimation predictor
// depends on der_pkg and the discrete_emission_reestimate rtl
`timescale 1ns / 1ps

module tb;

   localparam int ALPHA     = 16;
   localparam int HOLD_OFF  = 50;

   localparam logic [der_pkg::CSR_IDX_W-1:0] CSR_UNUSED_A = 2'd2;
   localparam logic [der_pkg::CSR_IDX_W-1:0] CSR_UNUSED_B = 2'd3;

   typedef struct packed {
      logic [der_pkg::SYM_W-1:0]  sym;
      logic [der_pkg::PROB_W-1:0] prob;
      logic                       fin;
   } entry_type;

   typedef enum logic [1:0] {RK_REQ, RK_FILL, RK_CSR} row_kind_type;

   // csr rows carry the register index in sym and the data in value
   typedef struct {
      row_kind_type               kind;
      logic                       cmd;
      logic [der_pkg::SYM_W-1:0]  sym;
      logic [der_pkg::PROB_W-1:0] value;
      logic                       last;
      logic                       fill_chk;
      logic [der_pkg::PROB_W-1:0] fill;
   } row_type;

   localparam int N_DIR = 24;

   row_type dir_rows [N_DIR] = '{
      '{RK_CSR,  der_pkg::CMD_LOAD, 4'(der_pkg::CSR_ENABLE_UPDATE), 17'd1, 1'b0, 1'b0, 17'd0},
      '{RK_CSR,  der_pkg::CMD_LOAD, 4'(der_pkg::CSR_LEARN_RATE), 17'h10000, 1'b0, 1'b0, 17'd0},
      '{RK_FILL, der_pkg::CMD_LOAD,    4'd0,  17'd0,       1'b0, 1'b0, 17'd0},
      // all-zero table and zero weight: blended sum is zero
      '{RK_REQ,  der_pkg::CMD_OBSERVE, 4'd0,  17'd0,       1'b1, 1'b1, 17'd0},
      // load above one, last mark on a load
      '{RK_REQ,  der_pkg::CMD_LOAD,    4'd0,  17'h1FFFF,   1'b1, 1'b0, 17'd0},
      '{RK_REQ,  der_pkg::CMD_LOAD,    4'd15, 17'h10000,   1'b0, 1'b0, 17'd0},
      '{RK_REQ,  der_pkg::CMD_LOAD,    4'd8,  17'd1,       1'b0, 1'b0, 17'd0},
      '{RK_REQ,  der_pkg::CMD_OBSERVE, 4'd15, 17'h1FFFF,   1'b0, 1'b0, 17'd0},
      '{RK_REQ,  der_pkg::CMD_OBSERVE, 4'd8,  17'd1,       1'b0, 1'b0, 17'd0},
      '{RK_REQ,  der_pkg::CMD_OBSERVE, 4'd0,  17'd0,       1'b1, 1'b0, 17'd0},
      '{RK_CSR,  der_pkg::CMD_LOAD, 4'(der_pkg::CSR_LEARN_RATE), 17'd0, 1'b0, 1'b0, 17'd0},
      '{RK_REQ,  der_pkg::CMD_OBSERVE, 4'd3,  17'h10000,   1'b1, 1'b0, 17'd0},
      // rate above one
      '{RK_CSR,  der_pkg::CMD_LOAD, 4'(der_pkg::CSR_LEARN_RATE), 17'h1FFFF, 1'b0, 1'b0, 17'd0},
      '{RK_REQ,  der_pkg::CMD_OBSERVE, 4'd4,  17'd12345,   1'b1, 1'b0, 17'd0},
      // disabled update, upper data bits set
      '{RK_CSR,  der_pkg::CMD_LOAD, 4'(der_pkg::CSR_ENABLE_UPDATE), 17'h1FFFE, 1'b0, 1'b0,
        17'd0},
      '{RK_REQ,  der_pkg::CMD_OBSERVE, 4'd9,  17'd500,     1'b0, 1'b0, 17'd0},
      '{RK_REQ,  der_pkg::CMD_OBSERVE, 4'd10, 17'd700,     1'b1, 1'b0, 17'd0},
      '{RK_CSR,  der_pkg::CMD_LOAD, 4'(der_pkg::CSR_ENABLE_UPDATE), 17'd1, 1'b0, 1'b0, 17'd0},
      '{RK_CSR,  der_pkg::CMD_LOAD, 4'(der_pkg::CSR_LEARN_RATE), 17'd32768, 1'b0, 1'b0, 17'd0},
      '{RK_CSR,  der_pkg::CMD_LOAD, 4'(CSR_UNUSED_A),      17'h1FFFF,   1'b0, 1'b0, 17'd0},
      '{RK_CSR,  der_pkg::CMD_LOAD, 4'(CSR_UNUSED_B),      17'h15555,   1'b0, 1'b0, 17'd0},
      '{RK_REQ,  der_pkg::CMD_OBSERVE, 4'd1,  17'h10000,   1'b0, 1'b0, 17'd0},
      '{RK_REQ,  der_pkg::CMD_OBSERVE, 4'd4,  17'd32768,   1'b1, 1'b0, 17'd0},
      // zero weight total with a live table
      '{RK_REQ,  der_pkg::CMD_OBSERVE, 4'd2,  17'd0,       1'b1, 1'b0, 17'd0}
   };

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic                          req_cmd;
   logic [der_pkg::SYM_W-1:0]     req_symbol;
   logic [der_pkg::PROB_W-1:0]    req_value;
   logic                          req_last;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [der_pkg::SYM_W-1:0]     rsp_out_symbol;
   logic [der_pkg::PROB_W-1:0]    rsp_probability;
   logic                          rsp_final_entry;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [der_pkg::CSR_IDX_W-1:0] csr_index;
   logic [der_pkg::PROB_W-1:0]    csr_data;

   // predictor state
   logic [der_pkg::PROB_W-1:0] prob_model [ALPHA];
   logic [der_pkg::ACC_W-1:0]  counts_model [ALPHA];
   logic [der_pkg::ACC_W-1:0]  total_model;
   logic                       en_model;
   logic [der_pkg::PROB_W-1:0] rate_model;

   entry_type pending_entries [$];

   int send_idle = 0;
   int recv_idle = 0;
   int req_count = 0;
   int csr_count = 0;
   int checked_count = 0;
   int err_count = 0;

   always #6 clock = ~clock;

   discrete_emission_reestimate #(.ALPHABET_SIZE(ALPHA)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_symbol(req_symbol),
      .req_value(req_value),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_symbol(rsp_out_symbol),
      .rsp_probability(rsp_probability),
      .rsp_final_entry(rsp_final_entry),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   function automatic logic [der_pkg::ACC_W-1:0] sat_acc(
         input logic [der_pkg::ACC_W-1:0] a, input logic [der_pkg::PROB_W-1:0] b);
      logic [der_pkg::ACC_W:0] s;
      s = {1'b0, a} + (der_pkg::ACC_W+1)'(b);
      return (s > (der_pkg::ACC_W+1)'(der_pkg::ACC_MAX)) ? der_pkg::ACC_MAX
                                                          : s[der_pkg::ACC_W-1:0];
   endfunction

   // applies one request transaction to the predicted table, returns the entries it emits
   function automatic int reestimate(input logic cmd, input logic [der_pkg::SYM_W-1:0] sym,
                                     input logic [der_pkg::PROB_W-1:0] val_in,
                                     input logic last, output entry_type emitted [ALPHA]);
      logic [der_pkg::PROB_W-1:0] val;
      logic [63:0]                blend [ALPHA];
      logic [63:0]                eta, sum, old, nw, p;
      int                         i;
      val = (val_in > der_pkg::ONE_Q16) ? der_pkg::ONE_Q16 : val_in;
      if (cmd == der_pkg::CMD_LOAD) begin
         prob_model[sym] = val;
         return 0;
      end
      counts_model[sym] = sat_acc(counts_model[sym], val);
      total_model = sat_acc(total_model, val);
      if (!last) return 0;
      if (!en_model) begin
         for (i = 0; i < ALPHA; i++) begin
            emitted[i] = '{sym: der_pkg::SYM_W'(i), prob: prob_model[i], fin: (i == ALPHA-1)};
            counts_model[i] = '0;
         end
         total_model = '0;
         return ALPHA;
      end
      eta = (rate_model > der_pkg::ONE_Q16) ? 64'(der_pkg::ONE_Q16) : 64'(rate_model);
      sum = '0;
      for (i = 0; i < ALPHA; i++) begin
         old = 64'(prob_model[i]);
         if (total_model == '0) nw = old;
         else nw = (64'(counts_model[i]) << 16) / 64'(total_model);
         blend[i] = (old * (64'(der_pkg::ONE_Q16) - eta) + nw * eta) >> 16;
         sum += blend[i];
      end
      for (i = 0; i < ALPHA; i++) begin
         p = (sum == '0) ? 64'd0 : (blend[i] << 16) / sum;
         prob_model[i] = p[der_pkg::PROB_W-1:0];
         emitted[i] = '{sym: der_pkg::SYM_W'(i), prob: p[der_pkg::PROB_W-1:0],
                        fin: (i == ALPHA-1)};
         counts_model[i] = '0;
      end
      total_model = '0;
      return ALPHA;
   endfunction

   function automatic logic [der_pkg::PROB_W-1:0] pick_q16();
      case ($urandom_range(5))
         0: return '0;
         1: return der_pkg::ONE_Q16;
         2: return der_pkg::PROB_W'($urandom);
         3: return der_pkg::PROB_W'($urandom_range(65536));
         4: return der_pkg::PROB_W'($urandom_range(255));
         default: return der_pkg::PROB_W'($urandom_range(8191));
      endcase
   endfunction

   // called just after a rising edge; leaves valid high on return
   task automatic issue_request(input logic cmd, input logic [der_pkg::SYM_W-1:0] sym,
                                input logic [der_pkg::PROB_W-1:0] val, input logic last,
                                input logic fill_chk,
                                input logic [der_pkg::PROB_W-1:0] fill);
      entry_type emitted [ALPHA];
      int        n, i;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_cmd    <= cmd;
      req_symbol <= sym;
      req_value  <= val;
      req_last   <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      req_count++;
      n = reestimate(cmd, sym, val, last, emitted);
      for (i = 0; i < n; i++) begin
         if (fill_chk) emitted[i].prob = fill;
         pending_entries.push_back(emitted[i]);
      end
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (pending_entries.size() != 0) @(posedge clock);
      repeat (HOLD_OFF) @(posedge clock);
   endtask

   task automatic csr_write(input logic [der_pkg::CSR_IDX_W-1:0] idx,
                            input logic [der_pkg::PROB_W-1:0] data);
      wait_until_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      csr_count++;
      if (idx == der_pkg::CSR_ENABLE_UPDATE) en_model = data[0];
      else if (idx == der_pkg::CSR_LEARN_RATE) rate_model = data;
   endtask

   task automatic run_directed();
      int r, k;
      for (r = 0; r < N_DIR; r++) begin
         case (dir_rows[r].kind)
            RK_CSR: csr_write(der_pkg::CSR_IDX_W'(dir_rows[r].sym), dir_rows[r].value);
            RK_FILL: begin
               for (k = 0; k < ALPHA; k++)
                  issue_request(der_pkg::CMD_LOAD, der_pkg::SYM_W'(k), dir_rows[r].value,
                                1'b0, 1'b0, '0);
            end
            default: issue_request(dir_rows[r].cmd, dir_rows[r].sym, dir_rows[r].value,
                                   dir_rows[r].last, dir_rows[r].fill_chk, dir_rows[r].fill);
         endcase
      end
   endtask

   task automatic random_traffic(input int n_items);
      int                         stop_at, len, k;
      logic [der_pkg::PROB_W-1:0] rate;
      stop_at = req_count + n_items;
      while (req_count < stop_at) begin
         if ($urandom_range(5) == 0) begin
            if ($urandom_range(1) == 0) begin
               csr_write(der_pkg::CSR_ENABLE_UPDATE,
                         {16'($urandom), ($urandom_range(99) < 85)});
            end else begin
               case ($urandom_range(4))
                  0: rate = '0;
                  1: rate = der_pkg::ONE_Q16;
                  2: rate = '1;
                  3: rate = der_pkg::PROB_W'($urandom);
                  default: rate = der_pkg::PROB_W'($urandom_range(65536));
               endcase
               csr_write(der_pkg::CSR_LEARN_RATE, rate);
            end
         end
         if ($urandom_range(3) == 0) begin
            for (k = 0; k < ALPHA; k++)
               issue_request(der_pkg::CMD_LOAD, der_pkg::SYM_W'(k), pick_q16(), 1'($urandom),
                             1'b0, '0);
         end
         len = $urandom_range(10, 1);
         for (k = 0; k < len; k++) begin
            // stray loads inside a sequence
            if ($urandom_range(9) == 0)
               issue_request(der_pkg::CMD_LOAD, der_pkg::SYM_W'($urandom), pick_q16(),
                             1'($urandom), 1'b0, '0);
            issue_request(der_pkg::CMD_OBSERVE, der_pkg::SYM_W'($urandom), pick_q16(),
                          (k == len-1), 1'b0, '0);
         end
      end
   endtask

   always @(posedge clock) begin
      entry_type exp_e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_entries.size() == 0) begin
            $error("unexpected result: out_symbol %0d probability %0d final_entry %0d",
                   rsp_out_symbol, rsp_probability, rsp_final_entry);
            err_count++;
         end else begin
            exp_e = pending_entries.pop_front();
            checked_count++;
            if (rsp_out_symbol !== exp_e.sym) begin
               $error("out_symbol expected %0d actual %0d", exp_e.sym, rsp_out_symbol);
               err_count++;
            end
            if (rsp_probability !== exp_e.prob) begin
               $error("probability expected %0d actual %0d", exp_e.prob, rsp_probability);
               err_count++;
            end
            if (rsp_final_entry !== exp_e.fin) begin
               $error("final_entry expected %0d actual %0d", exp_e.fin, rsp_final_entry);
               err_count++;
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   initial begin
      #(3_000_000 * 12);
      $display("status: fail");
      $finish;
   end

   initial begin
      int ph;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_cmd    = der_pkg::CMD_LOAD;
      req_symbol = '0;
      req_value  = '0;
      req_last   = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = der_pkg::CSR_ENABLE_UPDATE;
      csr_data   = '0;
      for (int i = 0; i < ALPHA; i++) begin
         prob_model[i]   = '0;
         counts_model[i] = '0;
      end
      total_model = '0;
      en_model    = 1'b1;
      rate_model  = der_pkg::ONE_Q16;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_idle = 33;
               recv_idle = 52;
            end
            1: begin
               send_idle = 52;
               recv_idle = 33;
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
            end
         endcase
         if (ph == 0) run_directed();
         random_traffic(130);
         wait_until_drained();
      end
      $display("ran %0d request transactions and %0d register writes under three idle mixes",
               req_count, csr_count);
      $display("checked %0d emitted entries across enabled, disabled and zero-sum updates",
               checked_count);
      if (err_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/der_pkg.sv
hw/rtl/der_ram.sv
hw/rtl/discrete_emission_reestimate.sv
bench/tb.sv
